@@ rtl/core/plls_pkg.sv @@
// ----------------------------------------------------------------------------
// plls_pkg: shared types and constants of the PLL divider search
// Beat structs, register indexes, divider handshake and post divider split.
// ----------------------------------------------------------------------------
package plls_pkg;

	localparam int DivW = 44;   // widest dividend: 32-bit rate times 12-bit divider
	localparam int DsrW = 32;   // widest divisor: the request

	localparam logic [2:0] RegRefDivMin = 3'd0;
	localparam logic [2:0] RegRefDivMax = 3'd1;
	localparam logic [2:0] RegFbDivMin  = 3'd2;
	localparam logic [2:0] RegFbDivMax  = 3'd3;
	localparam logic [2:0] RegVcoMinHz  = 3'd4;
	localparam logic [2:0] RegVcoMaxHz  = 3'd5;

	localparam logic [5:0] ProdDirectMax = 6'd7;
	localparam logic [5:0] ProdTableMax  = 6'd49;
	localparam logic [31:0] PfdMinHz     = 32'd10;

	typedef struct packed {
		logic [31:0] requested_rate;
		logic [31:0] reference_rate;
	} request_t;

	typedef struct packed {
		logic        found;
		logic [31:0] achieved_rate;
		logic [5:0]  chosen_ref_div;
		logic [11:0] chosen_fb_div;
		logic [2:0]  chosen_post_div1;
		logic [2:0]  chosen_post_div2;
	} result_t;

	typedef struct packed {
		logic            start;
		logic [DivW-1:0] dividend;
		logic [DsrW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DivW-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic [2:0] d1;
		logic [2:0] d2;
	} post_div_t;

	// product 1..49 -> post divider pair; 8..49 round up to the next table product
	function automatic post_div_t split_product(input logic [5:0] p);
		post_div_t r;
		case (p) inside
			[6'd1:6'd7]: r = '{d1: p[2:0], d2: 3'd1};
			6'd8:          r = '{d1: 3'd4, d2: 3'd2};
			6'd9:          r = '{d1: 3'd3, d2: 3'd3};
			6'd10:         r = '{d1: 3'd5, d2: 3'd2};
			[6'd11:6'd12]: r = '{d1: 3'd6, d2: 3'd2};
			[6'd13:6'd14]: r = '{d1: 3'd7, d2: 3'd2};
			6'd15:         r = '{d1: 3'd5, d2: 3'd3};
			6'd16:         r = '{d1: 3'd4, d2: 3'd4};
			[6'd17:6'd18]: r = '{d1: 3'd6, d2: 3'd3};
			[6'd19:6'd20]: r = '{d1: 3'd5, d2: 3'd4};
			6'd21:         r = '{d1: 3'd7, d2: 3'd3};
			[6'd22:6'd24]: r = '{d1: 3'd6, d2: 3'd4};
			6'd25:         r = '{d1: 3'd5, d2: 3'd5};
			[6'd26:6'd28]: r = '{d1: 3'd7, d2: 3'd4};
			[6'd29:6'd30]: r = '{d1: 3'd6, d2: 3'd5};
			[6'd31:6'd35]: r = '{d1: 3'd7, d2: 3'd5};
			6'd36:         r = '{d1: 3'd6, d2: 3'd6};
			[6'd37:6'd42]: r = '{d1: 3'd7, d2: 3'd6};
			[6'd43:6'd49]: r = '{d1: 3'd7, d2: 3'd7};
			default:       r = '{d1: 3'd1, d2: 3'd1};
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/plls_divider.sv @@
// ----------------------------------------------------------------------------
// plls_divider: bit-serial restoring divider
// One quotient bit per cycle; dividend shifts out as the quotient shifts in.
// ----------------------------------------------------------------------------
module plls_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  plls_pkg::div_req_t req,
	output plls_pkg::div_rsp_t rsp
);

	localparam logic [5:0] Steps = 6'(plls_pkg::DivW);

	logic                      run_q;
	logic                      done_q;
	logic [5:0]                cnt_q;
	logic [plls_pkg::DsrW-1:0] rem_q;
	logic [plls_pkg::DsrW-1:0] dsr_q;
	logic [plls_pkg::DivW-1:0] dq_q;
	logic [plls_pkg::DsrW:0]   trial;
	logic [plls_pkg::DsrW:0]   diff;

	assign trial = {rem_q, dq_q[plls_pkg::DivW-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= Steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			dq_q  <= req.dividend;
		end else if (run_q) begin
			if (!diff[plls_pkg::DsrW]) begin
				rem_q <= diff[plls_pkg::DsrW-1:0];
				dq_q  <= {dq_q[plls_pkg::DivW-2:0], 1'b1};
			end else begin
				rem_q <= trial[plls_pkg::DsrW-1:0];
				dq_q  <= {dq_q[plls_pkg::DivW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

@@ rtl/core/pll_divider_search.sv @@
// ----------------------------------------------------------------------------
// pll_divider_search: PLL reference / feedback / post divider search
// Walks R over the reference divider range and F over the feedback range,
// keeping the candidate closest to the request; stops on an exact hit.
// ----------------------------------------------------------------------------
// Sequence from the accepting edge: per R a range check, a wait on the PFD
//   divide and a closing F check; per F tried one to three 44-bit serial
//   divides (VCO, product, output rate), and the DONE state to end.
// Throughput: one search at a time; start is taken only while busy is low.
// The result is a one-cycle strobe (result_valid); the receiver cannot stall.
// Reset: config registers return to their defaults, sequencer goes idle.
module pll_divider_search (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  plls_pkg::request_t request,
	output logic               result_valid,
	output plls_pkg::result_t  result,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	// sequencer codes
	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_RLOOP     = 4'd1;  // test R, launch PFD divide
	localparam logic [3:0] S_PFD_WAIT  = 4'd2;
	localparam logic [3:0] S_FLOOP     = 4'd3;  // test F, form fref*F
	localparam logic [3:0] S_VCO_GO    = 4'd4;
	localparam logic [3:0] S_VCO_WAIT  = 4'd5;
	localparam logic [3:0] S_PROD_GO   = 4'd6;
	localparam logic [3:0] S_PROD_WAIT = 4'd7;
	localparam logic [3:0] S_RATE_GO   = 4'd8;
	localparam logic [3:0] S_RATE_WAIT = 4'd9;
	localparam logic [3:0] S_DONE      = 4'd10;

	// configuration
	logic [5:0]  ref_div_min_q, ref_div_max_q;
	logic [11:0] fb_div_min_q, fb_div_max_q;
	logic [31:0] vco_min_q, vco_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_div_min_q <= 6'd1;
			ref_div_max_q <= 6'd63;
			fb_div_min_q  <= 12'd16;
			fb_div_max_q  <= 12'd320;
			vco_min_q     <= 32'd1600000000;
			vco_max_q     <= 32'd3200000000;
		end else if (cfg_we) begin
			case (cfg_index)
				plls_pkg::RegRefDivMin: ref_div_min_q <= cfg_data[5:0];
				plls_pkg::RegRefDivMax: ref_div_max_q <= cfg_data[5:0];
				plls_pkg::RegFbDivMin:  fb_div_min_q  <= cfg_data[11:0];
				plls_pkg::RegFbDivMax:  fb_div_max_q  <= cfg_data[11:0];
				plls_pkg::RegVcoMinHz:  vco_min_q     <= cfg_data;
				plls_pkg::RegVcoMaxHz:  vco_max_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [3:0]  state_q;
	logic [31:0] req_q, fref_q, pfd_q, vco_q;
	logic [6:0]  r_q;       // one bit spare so R can step past 63
	logic [12:0] f_q;       // one bit spare so F can step past 4095
	logic [plls_pkg::DivW-1:0] mul_q;
	plls_pkg::post_div_t pd_q;

	// best candidate so far; dist starts at the request (best rate 0)
	logic        found_q;
	logic [31:0] best_rate_q, best_dist_q;
	logic [5:0]  best_r_q;
	logic [11:0] best_f_q;
	plls_pkg::post_div_t best_pd_q;

	plls_pkg::div_req_t div_req;
	plls_pkg::div_rsp_t div_rsp;

	plls_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// divider launch: operand chosen by the state issuing the beat
	always_comb begin
		div_req = '0;
		case (state_q)
			S_RLOOP: begin
				div_req.start    = (r_q <= {1'b0, ref_div_max_q}) && (r_q != 7'd0);
				div_req.dividend = {12'd0, fref_q};
				div_req.divisor  = {25'd0, r_q};
			end
			S_VCO_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = mul_q;
				div_req.divisor  = {25'd0, r_q};
			end
			S_PROD_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = mul_q;
				div_req.divisor  = req_q;
			end
			S_RATE_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {12'd0, vco_q};
				div_req.divisor  = {26'd0, 6'(pd_q.d1 * pd_q.d2)};
			end
			default: ;
		endcase
	end

	// quotient checks
	logic [plls_pkg::DivW-1:0] quo;
	logic                      vco_ok, prod_ok, better;
	logic [31:0]               dist_new;

	assign quo     = div_rsp.quotient;
	assign vco_ok  = (quo[43:32] == 12'd0) && (quo[31:0] >= vco_min_q)
	                 && (quo[31:0] <= vco_max_q);
	assign prod_ok = (quo[43:6] == 38'd0) && (quo[5:0] != 6'd0)
	                 && (quo[5:0] <= plls_pkg::ProdTableMax);
	// output rate never exceeds the VCO rate, which fits 32 bits here
	assign dist_new = (quo[31:0] >= req_q) ? (quo[31:0] - req_q) : (req_q - quo[31:0]);
	assign better   = dist_new < best_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						found_q <= 1'b0;
						state_q <= S_RLOOP;
					end
				end
				S_RLOOP: begin
					if (r_q > {1'b0, ref_div_max_q})
						state_q <= S_DONE;
					else if (r_q != 7'd0)
						state_q <= S_PFD_WAIT;
				end
				S_PFD_WAIT: if (div_rsp.done) state_q <= S_FLOOP;
				S_FLOOP: begin
					// low PFD or zero request disqualifies every F of this R
					if (f_q > {1'b0, fb_div_max_q} || pfd_q < plls_pkg::PfdMinHz
					    || req_q == 32'd0)
						state_q <= S_RLOOP;
					else
						state_q <= S_VCO_GO;
				end
				S_VCO_GO:  state_q <= S_VCO_WAIT;
				S_VCO_WAIT: if (div_rsp.done) state_q <= vco_ok ? S_PROD_GO : S_FLOOP;
				S_PROD_GO: state_q <= S_PROD_WAIT;
				S_PROD_WAIT: if (div_rsp.done) state_q <= prod_ok ? S_RATE_GO : S_FLOOP;
				S_RATE_GO: state_q <= S_RATE_WAIT;
				S_RATE_WAIT: begin
					if (div_rsp.done) begin
						if (better) begin
							found_q <= 1'b1;
							state_q <= (dist_new == 32'd0) ? S_DONE : S_FLOOP;
						end else begin
							state_q <= S_FLOOP;
						end
					end
				end
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q       <= request.requested_rate;
					fref_q      <= request.reference_rate;
					r_q         <= {1'b0, ref_div_min_q};
					best_dist_q <= request.requested_rate;
					best_rate_q <= '0;
					best_r_q    <= '0;
					best_f_q    <= '0;
					best_pd_q   <= '0;
				end
			end
			S_RLOOP: if (r_q == 7'd0) r_q <= 7'd1;
			S_PFD_WAIT: begin
				if (div_rsp.done) begin
					pfd_q <= quo[31:0];
					f_q   <= {1'b0, fb_div_min_q};
				end
			end
			S_FLOOP: begin
				if (f_q > {1'b0, fb_div_max_q} || pfd_q < plls_pkg::PfdMinHz
				    || req_q == 32'd0)
					r_q <= r_q + 7'd1;
				else
					mul_q <= fref_q * f_q[11:0];
			end
			S_VCO_WAIT: begin
				if (div_rsp.done) begin
					vco_q <= quo[31:0];
					mul_q <= pfd_q * f_q[11:0];
					if (!vco_ok) f_q <= f_q + 13'd1;
				end
			end
			S_PROD_WAIT: begin
				if (div_rsp.done) begin
					pd_q <= plls_pkg::split_product(quo[5:0]);
					if (!prod_ok) f_q <= f_q + 13'd1;
				end
			end
			S_RATE_WAIT: begin
				if (div_rsp.done) begin
					f_q <= f_q + 13'd1;
					if (better) begin
						best_dist_q <= dist_new;
						best_rate_q <= quo[31:0];
						best_r_q    <= r_q[5:0];
						best_f_q    <= f_q[11:0];
						best_pd_q   <= pd_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = (state_q == S_DONE);

	always_comb begin
		result                  = '0;
		result.found            = found_q;
		result.achieved_rate    = best_rate_q;
		result.chosen_ref_div   = best_r_q;
		result.chosen_fb_div    = best_f_q;
		result.chosen_post_div1 = best_pd_q.d1;
		result.chosen_post_div2 = best_pd_q.d2;
	end

endmodule

@@ rtl/core/plls_checker.sv @@
// ----------------------------------------------------------------------------
// plls_checker: port-level checks of the PLL divider search
// Accept and result strobe timing against busy, and the shape of miss and hit results.
// ----------------------------------------------------------------------------
module plls_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_valid,
	input plls_pkg::result_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid && !busy)
		else $error("result strobe longer than one cycle or busy held");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe while idle");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |-> result.achieved_rate == 32'd0
		&& result.chosen_ref_div == 6'd0 && result.chosen_fb_div == 12'd0)
		else $error("miss result carries nonzero fields");

	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.found |-> result.achieved_rate != 32'd0
		&& result.chosen_post_div1 != 3'd0 && result.chosen_post_div2 != 3'd0)
		else $error("hit result with zero rate or post divider");

endmodule

bind pll_divider_search plls_checker u_plls_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

@@ tb/sv/tb_pll_divider_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pll_divider_search: self-checking bench for the PLL divider search
// Programs small divider ranges, sends rate requests in random bursts and
// checks each result beat against a software search run on the same config.
// ----------------------------------------------------------------------------

// Software search and result bookkeeping
class divider_scoreboard;
	bit [5:0]  ref_div_min = 6'd1;
	bit [5:0]  ref_div_max = 6'd63;
	bit [11:0] fb_div_min  = 12'd16;
	bit [11:0] fb_div_max  = 12'd320;
	bit [31:0] vco_min_hz  = 32'd1600000000;
	bit [31:0] vco_max_hz  = 32'd3200000000;
	plls_pkg::result_t pending_results[$];
	int errors = 0;

	// register image follows every write to the block
	function void set_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			plls_pkg::RegRefDivMin: ref_div_min = val[5:0];
			plls_pkg::RegRefDivMax: ref_div_max = val[5:0];
			plls_pkg::RegFbDivMin:  fb_div_min  = val[11:0];
			plls_pkg::RegFbDivMax:  fb_div_max  = val[11:0];
			plls_pkg::RegVcoMinHz:  vco_min_hz  = val;
			plls_pkg::RegVcoMaxHz:  vco_max_hz  = val;
			default: ;
		endcase
	endfunction

	static function longint unsigned gap(longint unsigned a, longint unsigned b);
		return (a > b) ? a - b : b - a;
	endfunction

	function plls_pkg::result_t search(bit [31:0] req, bit [31:0] fref);
		// table of {small, large, product}; products past 7 round up
		int pairs[18][3] = '{'{2,4,8}, '{3,3,9}, '{2,5,10}, '{2,6,12}, '{2,7,14},
			'{3,5,15}, '{4,4,16}, '{3,6,18}, '{4,5,20}, '{3,7,21}, '{4,6,24},
			'{5,5,25}, '{4,7,28}, '{5,6,30}, '{5,7,35}, '{6,6,36}, '{6,7,42},
			'{7,7,49}};
		longint unsigned best_rate, pfd, vco, prod, rate;
		int best_r, best_f, best_d1, best_d2, d1, d2;
		bit hit;
		plls_pkg::result_t res;
		best_rate = 0; best_r = 0; best_f = 0; best_d1 = 0; best_d2 = 0;
		hit = 0;
		for (int r = ref_div_min; r <= ref_div_max && !hit; r++) begin
			if (r == 0) continue;
			pfd = fref / r;
			for (int f = fb_div_min; f <= fb_div_max; f++) begin
				vco = (longint'(fref) * f) / r;
				if (vco < vco_min_hz || vco > vco_max_hz || pfd < 10) continue;
				if (req == 0) continue;
				prod = (pfd * f) / req;
				if (prod == 0 || prod > 49) continue;
				if (prod <= 7) begin
					d1 = int'(prod); d2 = 1;
				end else begin
					for (int i = 17; i >= 0; i--)
						if (prod <= pairs[i][2]) begin
							d1 = pairs[i][1]; d2 = pairs[i][0];
						end
				end
				rate = vco / (d1 * d2);
				if (gap(rate, req) < gap(best_rate, req)) begin
					best_rate = rate; best_r = r; best_f = f;
					best_d1 = d1; best_d2 = d2;
					if (rate == req) begin
						hit = 1;
						break;
					end
				end
			end
		end
		res = '0;
		if (best_rate != 0) begin
			res.found            = 1'b1;
			res.achieved_rate    = best_rate[31:0];
			res.chosen_ref_div   = best_r[5:0];
			res.chosen_fb_div    = best_f[11:0];
			res.chosen_post_div1 = best_d1[2:0];
			res.chosen_post_div2 = best_d2[2:0];
		end
		return res;
	endfunction

	function void note_request(plls_pkg::request_t rq);
		pending_results.push_back(search(rq.requested_rate, rq.reference_rate));
	endfunction

	function void check_result(plls_pkg::result_t got);
		plls_pkg::result_t exp;
		if (pending_results.size() == 0) begin
			$error("result beat with nothing pending");
			errors++;
			return;
		end
		exp = pending_results.pop_front();
		if (got.found !== exp.found) begin
			$error("found: expected %0d, got %0d", exp.found, got.found); errors++;
		end
		if (got.achieved_rate !== exp.achieved_rate) begin
			$error("achieved_rate: expected %0d, got %0d", exp.achieved_rate,
				got.achieved_rate); errors++;
		end
		if (got.chosen_ref_div !== exp.chosen_ref_div) begin
			$error("chosen_ref_div: expected %0d, got %0d", exp.chosen_ref_div,
				got.chosen_ref_div); errors++;
		end
		if (got.chosen_fb_div !== exp.chosen_fb_div) begin
			$error("chosen_fb_div: expected %0d, got %0d", exp.chosen_fb_div,
				got.chosen_fb_div); errors++;
		end
		if (got.chosen_post_div1 !== exp.chosen_post_div1) begin
			$error("chosen_post_div1: expected %0d, got %0d", exp.chosen_post_div1,
				got.chosen_post_div1); errors++;
		end
		if (got.chosen_post_div2 !== exp.chosen_post_div2) begin
			$error("chosen_post_div2: expected %0d, got %0d", exp.chosen_post_div2,
				got.chosen_post_div2); errors++;
		end
	endfunction
endclass

module tb_pll_divider_search;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	plls_pkg::request_t request = '0;
	logic               result_valid;
	plls_pkg::result_t  result;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = plls_pkg::RegRefDivMin;
	logic [31:0]        cfg_data = '0;

	divider_scoreboard sb = new();

	pll_divider_search i_dut (
		.clk, .arst_n, .start, .busy, .request,
		.result_valid, .result, .cfg_we, .cfg_index, .cfg_data
	);

	always #5 clk = ~clk;

	// results cannot be held off: take every strobed beat
	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(result);
	end

	// config write; caller drops cfg_we after the last one
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// only called while idle: nothing pending
	task automatic program_ranges(bit [5:0] rmin, bit [5:0] rmax, bit [11:0] fmin,
		bit [11:0] fmax, bit [31:0] vmin, bit [31:0] vmax);
		write_reg(plls_pkg::RegRefDivMin, {26'd0, rmin});
		write_reg(plls_pkg::RegRefDivMax, {26'd0, rmax});
		write_reg(plls_pkg::RegFbDivMin, {20'd0, fmin});
		write_reg(plls_pkg::RegFbDivMax, {20'd0, fmax});
		write_reg(plls_pkg::RegVcoMinHz, vmin);
		write_reg(plls_pkg::RegVcoMaxHz, vmax);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// hold start until the block takes the beat, then maybe idle a while
	task automatic send_request(bit [31:0] req, bit [31:0] fref);
		plls_pkg::request_t rq;
		rq.requested_rate = req;
		rq.reference_rate = fref;
		start   <= 1'b1;
		request <= rq;
		do @(posedge clk); while (busy);
		sb.note_request(rq);
		// bursts: mostly back to back, sometimes a gap of random length
		if ($urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// let the block drain before touching the registers again
	task automatic drain();
		start <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		bit [5:0]  rmin, rmax;
		bit [11:0] fmin, fmax;
		bit [31:0] fref, req, vmin, vmax;
		longint unsigned vco;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small ranges, full VCO window: rate and reference extremes
		program_ranges(6'd1, 6'd2, 12'd1, 12'd8, 32'd0, 32'hFFFF_FFFF);
		send_request(32'd1, 32'd100);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'd1, 32'hFFFF_FFFF);     // product far above the table
		send_request(32'd0, 32'd1000);          // zero request: nothing wins
		send_request(32'd50, 32'd9);            // PFD below 10 Hz
		send_request(32'd1000, 32'd1);
		send_request(32'd100, 32'd1000);        // exact hit ends early
		send_request(32'd7, 32'd25);
		drain();

		// top of both divider ranges
		program_ranges(6'd62, 6'd63, 12'd4088, 12'd4095, 32'd0, 32'hFFFF_FFFF);
		send_request(32'd25_000_000, 32'd100_000_000);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'd123_456_789, 32'd38_400_000);
		drain();

		// reference divider range starting at zero, default VCO window
		program_ranges(6'd0, 6'd1, 12'd60, 12'd70, 32'd1600000000, 32'd3200000000);
		send_request(32'd400_000_000, 32'd40_000_000);
		send_request(32'd333_333_333, 32'd25_000_000);
		drain();

		// empty ranges: min above max on each register pair
		program_ranges(6'd5, 6'd4, 12'd10, 12'd12, 32'd0, 32'hFFFF_FFFF);
		send_request(32'd1000, 32'd10000);
		drain();
		program_ranges(6'd1, 6'd2, 12'd12, 12'd10, 32'd0, 32'hFFFF_FFFF);
		send_request(32'd1000, 32'd10000);
		drain();
		program_ranges(6'd1, 6'd2, 12'd10, 12'd12, 32'hFFFF_FFFF, 32'd0);
		send_request(32'd1000, 32'd10000);
		drain();

		// random phases: narrow ranges, requests aimed at reachable rates
		for (int ph = 0; ph < 9; ph++) begin
			rmin = 6'($urandom_range(1, 63));
			rmax = (rmin > 60) ? 6'd63 : 6'(rmin + $urandom_range(0, 3));
			fmin = 12'($urandom_range(1, 4080));
			fmax = 12'(fmin + $urandom_range(0, 15));
			fref = $urandom_range(1_000, 200_000_000);
			vco  = (longint'(fref) * fmin) / rmin;
			case ($urandom_range(0, 2))
				0: begin vmin = 32'd0; vmax = 32'hFFFF_FFFF; end
				1: begin
					vmin = (vco > 32'hFFFF_FFFF) ? 32'hF000_0000 : vco[31:0] / 2;
					vmax = (vco * 3 > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(vco * 3);
				end
				default: begin vmin = $urandom; vmax = $urandom; end
			endcase
			program_ranges(rmin, rmax, fmin, fmax, vmin, vmax);
			for (int n = 0; n < 11; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_request($urandom, $urandom);
				end else begin
					// same reference, rate near the VCO over some product
					vco = (longint'(fref) * (fmin + $urandom_range(0, fmax - fmin)))
						/ rmin;
					req = 32'(vco / $urandom_range(1, 56));
					if ($urandom_range(0, 1)) req = req + $urandom_range(0, 50) - 25;
					send_request(req, fref);
				end
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// generous watchdog
	initial begin
		#200ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/plls_pkg.sv
rtl/core/plls_divider.sv
rtl/core/pll_divider_search.sv
rtl/core/plls_checker.sv
tb/sv/tb_pll_divider_search.sv
